// ===== hdl/fbfa_pkg.sv =====
// ============================================================================
// Fixed block free list allocator package
// Field widths, function and status codes, register indexes and the helper
// that clamps a block count into the legal range of the pool.
// ============================================================================
package fbfa_pkg;

  // Pool size limit by default.
  localparam int unsigned MAX_BLOCKS_DEF  = 1024;
  // Initial block count after reset.
  localparam int unsigned INIT_BLOCKS_RST = 64;

  // Fixed field widths.
  localparam int unsigned FUNC_W       = 1;
  localparam int unsigned FREE_IDX_W   = 10;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned BIDX_W       = 10;
  localparam int unsigned CNT_W        = 11;
  localparam int unsigned IN_TDATA_W   = 16;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned CFG_DATA_W   = 11;
  localparam int unsigned CFG_IDX_W    = 1;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GROW_ON_FULL   = 1'b1;

  // A count of zero becomes one; anything above the pool limit becomes the limit.
  function automatic logic [31:0] clamp_blocks(input logic [31:0] v,
                                               input logic [31:0] maxb);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > maxb) begin
      r = maxb;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/fbfa_link_ram.sv =====
// ============================================================================
// Free list link memory
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ============================================================================
module fbfa_link_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fbfa_ctrl.sv =====
// ============================================================================
// Allocator control
// Holds the free list head, fresh block counter, capacity and use count,
// decides each request and drives the link memory and the result register.
// ============================================================================
module fbfa_ctrl
  import fbfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned IW         = 10,
  parameter int unsigned LW         = 11,
  parameter int unsigned CW         = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [FREE_IDX_W-1:0]  in_free_index,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cap_load,
  input  logic [CW-1:0]          cap_value,
  input  logic                   grow,
  output logic                   mem_we,
  output logic [IW-1:0]          mem_waddr,
  output logic [LW-1:0]          mem_wdata,
  output logic                   mem_re,
  output logic [IW-1:0]          mem_raddr,
  input  logic [LW-1:0]          mem_rdata
);

  typedef enum logic {S_IDLE, S_POP} state_t;

  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);
  localparam logic [CW:0]   MAX_DBL   = (CW+1)'(MAX_BLOCKS);
  localparam logic [CW-1:0] MAX_CAP   = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] CAP_RST   =
    CW'(clamp_blocks(32'(INIT_BLOCKS_RST), 32'(MAX_BLOCKS)));

  state_t                 state_r, state_nxt;
  logic [LW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          fresh_r, fresh_nxt;
  logic [CW-1:0]          cap_r, cap_nxt;
  logic [CW-1:0]          used_r, used_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic          accept;
  logic [CW-1:0] ext_idx;
  logic [CW:0]   cap_dbl;
  logic [CW-1:0] cap_grown;
  logic [CW-1:0] given;
  logic [STATUS_W-1:0] status;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign ext_idx   = CW'(in_free_index);
  assign cap_dbl   = {cap_r, 1'b0};
  assign cap_grown = (cap_dbl > MAX_DBL) ? MAX_CAP : cap_dbl[CW-1:0];

  assign mem_raddr = head_r[IW-1:0];
  assign mem_waddr = ext_idx[IW-1:0];
  assign mem_wdata = head_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fresh_nxt     = fresh_r;
    cap_nxt       = cap_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    given         = '0;
    status        = STATUS_OK;

    // A reload of the initial size only counts before any block was handed out.
    if (cap_load && (fresh_r == '0)) begin
      cap_nxt = cap_value;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_ALLOC) begin
            if (head_r != NULL_LINK) begin
              // Pop: the link of the head arrives next cycle.
              mem_re    = 1'b1;
              given     = CW'(head_r);
              used_nxt  = used_r + 1'b1;
              state_nxt = S_POP;
            end else begin
              if ((fresh_r >= cap_r) && grow && (cap_r < MAX_CAP)) begin
                cap_nxt = cap_grown;
              end
              if (fresh_r < cap_nxt) begin
                given     = fresh_r;
                fresh_nxt = fresh_r + 1'b1;
                used_nxt  = used_r + 1'b1;
              end else begin
                status = STATUS_NO_BLOCK;
              end
            end
          end else begin
            if ((ext_idx >= cap_r) || (used_r == '0)) begin
              status = STATUS_BAD_FREE;
            end else begin
              mem_we   = 1'b1;
              head_nxt = ext_idx[LW-1:0];
              used_nxt = used_r - 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, cap_nxt[CNT_W-1:0], used_nxt[CNT_W-1:0],
                           given[BIDX_W-1:0], status};
        end
      end
      S_POP: begin
        head_nxt  = mem_rdata;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_LINK;
      fresh_r     <= '0;
      cap_r       <= CAP_RST;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fresh_r     <= fresh_nxt;
      cap_r       <= cap_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/fixed_block_free_list_allocator_top.sv =====
// ============================================================================
// Fixed block free list allocator
// Result: offered in the cycle after its request beat is taken.
// Throughput: one beat per cycle while the result channel does not stall;
// an allocation from the free list holds off the next beat until the link read refills the head.
// Reset: synchronous, active low; the free list is empty, nothing is in use
// and the capacity is the default initial size. The link memory is not cleared.
// ============================================================================
module fixed_block_free_list_allocator_top
  import fbfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Request channel.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // [9:0] free_index, [15:10] zero
  input  logic [FUNC_W-1:0]      in_tuser,  // [0] func
  // Result channel.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata, // [1:0] status, [11:2] block_index,
                                            // [22:12] in_use_count,
                                            // [33:23] capacity, [39:34] zero
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Index width of the link memory, width of a link (which also has to hold
  // the null marker equal to the pool limit) and width of the counters,
  // which is never narrower than the configured size field.
  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned LW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW  = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

  logic          grow_r, grow_nxt;
  logic          cap_load;
  logic [CW-1:0] cap_value;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic          mem_re;
  logic [IW-1:0] mem_raddr;
  logic [LW-1:0] mem_rdata;

  // Configuration writes are always taken. The initial size is clamped here
  // and offered to the control as a reload; the control ignores it once the
  // first fresh block has been handed out.
  assign cfg_ready = 1'b1;
  assign cap_load  = cfg_valid && (cfg_index == REG_INITIAL_BLOCKS);
  assign cap_value = CW'(clamp_blocks(32'(cfg_data), 32'(MAX_BLOCKS)));

  always_comb begin
    grow_nxt = grow_r;
    if (cfg_valid && (cfg_index == REG_GROW_ON_FULL)) begin
      grow_nxt = cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grow_r <= 1'b0;
    end else begin
      grow_r <= grow_nxt;
    end
  end

  // Request decisions, counters, list head and the result register.
  fbfa_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .IW        (IW),
    .LW        (LW),
    .CW        (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_func      (in_tuser),
    .in_free_index(in_tdata[FREE_IDX_W-1:0]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cap_load     (cap_load),
    .cap_value    (cap_value),
    .grow         (grow_r),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  // Each entry holds the index that follows it on the free list.
  fbfa_link_ram #(
    .DEPTH(MAX_BLOCKS),
    .AW   (IW),
    .DW   (LW)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
